// ===== src/flr_pkg.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer package
// Screen geometry, field widths, operation codes and the job record that
// passes from the front end to the drawing engine.
// ----------------------------------------------------------------------------
package flr_pkg;

  localparam int SCREEN_COLUMNS = 128;
  localparam int SCREEN_PAGES   = 8;
  localparam int STORE_SIZE     = SCREEN_COLUMNS * SCREEN_PAGES;
  localparam int ADDR_W         = $clog2(STORE_SIZE);

  localparam int OP_W    = 2;
  localparam int X_W     = 7;
  localparam int Y_W     = 6;
  localparam int PAGE_W  = 3;
  localparam int BYTE_W  = 8;
  localparam int ROW_W   = 3;           // row within a page
  localparam int ACC_W   = X_W + 1;     // error accumulator, holds up to twice the span

  localparam int QUEUE_DEPTH = 2;

  localparam logic [OP_W-1:0] OP_DRAW  = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  typedef enum logic [1:0] {
    JOB_DRAW  = 2'd0,
    JOB_CLEAR = 2'd1,
    JOB_READ  = 2'd2,
    JOB_NONE  = 2'd3
  } job_kind_t;

  typedef struct packed {
    job_kind_t         kind;
    logic [X_W-1:0]    x;
    logic [Y_W-1:0]    y;
    logic [X_W-1:0]    dx;
    logic [Y_W-1:0]    dy;
    logic [X_W-1:0]    major_span;
    logic              x_neg;
    logic              y_neg;
    logic              pixel_value;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_ok;
  } job_t;

  function automatic logic [ADDR_W-1:0] store_addr(input logic [PAGE_W-1:0] page,
                                                    input logic [X_W-1:0] col);
    return ADDR_W'(int'(page) * SCREEN_COLUMNS + int'(col));
  endfunction

endpackage

// ===== src/flr_if.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer channels
// Command and response channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface flr_cmd_if;
  import flr_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [X_W-1:0]    x_start;
  logic [Y_W-1:0]    y_start;
  logic [X_W-1:0]    x_end;
  logic [Y_W-1:0]    y_end;
  logic              pixel_value;
  logic [X_W-1:0]    read_column;
  logic [PAGE_W-1:0] read_page;

  modport source (output valid, operation, x_start, y_start, x_end, y_end, pixel_value,
                  read_column, read_page, input ready);
  modport sink (input valid, operation, x_start, y_start, x_end, y_end, pixel_value,
                read_column, read_page, output ready);
endinterface

interface flr_rsp_if;
  import flr_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

// ===== src/flr_front.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer front end
// Accepts commands, decodes the operation and works out the line spans,
// directions and read address for the engine.
// ----------------------------------------------------------------------------
module flr_front (
  flr_cmd_if.sink      command,
  input  logic         init_busy,
  input  logic         q_full,
  output logic         push,
  output flr_pkg::job_t push_job
);
  import flr_pkg::*;

  logic [X_W-1:0] dx;
  logic [Y_W-1:0] dy;
  logic           x_neg;
  logic           y_neg;

  // Nothing is taken while the store is being wiped after reset.
  assign command.ready = !q_full && !init_busy;
  assign push          = command.valid && command.ready;

  assign x_neg = command.x_end < command.x_start;
  assign y_neg = command.y_end < command.y_start;
  assign dx    = x_neg ? command.x_start - command.x_end : command.x_end - command.x_start;
  assign dy    = y_neg ? command.y_start - command.y_end : command.y_end - command.y_start;

  always_comb begin
    case (command.operation)
      OP_DRAW:  push_job.kind = JOB_DRAW;
      OP_CLEAR: push_job.kind = JOB_CLEAR;
      OP_READ:  push_job.kind = JOB_READ;
      default:  push_job.kind = JOB_NONE;
    endcase
    push_job.x           = command.x_start;
    push_job.y           = command.y_start;
    push_job.dx          = dx;
    push_job.dy          = dy;
    push_job.major_span  = (dx > X_W'(dy)) ? dx : X_W'(dy);
    push_job.x_neg       = x_neg;
    push_job.y_neg       = y_neg;
    push_job.pixel_value = command.pixel_value;
    push_job.rd_addr     = store_addr(command.read_page, command.read_column);
    push_job.rd_ok       = (int'(command.read_column) < SCREEN_COLUMNS) &&
                           (int'(command.read_page) < SCREEN_PAGES);
  end

endmodule

// ===== src/flr_queue.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer job queue
// Short first-in first-out queue between the front end and the engine.
// ----------------------------------------------------------------------------
module flr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  flr_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output flr_pkg::job_t pop_job,
  output logic          not_empty
);
  import flr_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = count == CNT_W'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign pop_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/flr_back.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer engine
// Holds the framebuffer and carries out jobs one at a time: line walks with
// a read-modify-write per pixel, clearing sweeps and byte reads.
// ----------------------------------------------------------------------------
module flr_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  flr_pkg::job_t q_job,
  output logic          q_pop,
  output logic          init_busy,
  flr_rsp_if.source     response
);
  import flr_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_CLEAR     = 6'b000010,
    ST_DRAW_RD   = 6'b000100,
    ST_DRAW_WR   = 6'b001000,
    ST_READ_WAIT = 6'b010000,
    ST_RESULT    = 6'b100000
  } state_t;

  state_t            state;
  logic [BYTE_W-1:0] mem [STORE_SIZE];
  logic [BYTE_W-1:0] rd_data;
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we;
  logic [BYTE_W-1:0] mem_wdata;

  logic [ADDR_W-1:0] clr_addr;
  logic              clr_init;

  logic [X_W-1:0]    cx;
  logic [Y_W-1:0]    cy;
  logic [ACC_W-1:0]  ex;
  logic [ACC_W-1:0]  ey;
  logic [X_W-1:0]    dx;
  logic [Y_W-1:0]    dy;
  logic [X_W-1:0]    major_span;
  logic [X_W-1:0]    remaining;
  logic              x_neg;
  logic              y_neg;
  logic              pixel_value;
  logic              rd_ok;

  logic [BYTE_W-1:0] res_data;
  logic              rsp_valid;
  logic [BYTE_W-1:0] rsp_data;

  logic [PAGE_W-1:0] pix_page;
  logic [BYTE_W-1:0] pix_mask;
  logic              pix_ok;
  logic [ADDR_W-1:0] pix_addr;
  logic [ACC_W-1:0]  ex_sum;
  logic [ACC_W-1:0]  ey_sum;
  logic              ex_step;
  logic              ey_step;
  logic              out_free;

  assign init_busy = clr_init;
  assign q_pop     = (state == ST_IDLE) && q_valid;
  assign out_free  = !rsp_valid || response.ready;

  assign response.valid     = rsp_valid;
  assign response.read_data = rsp_data;

  assign pix_page = cy[Y_W-1:ROW_W];
  assign pix_mask = BYTE_W'(1) << cy[ROW_W-1:0];
  assign pix_ok   = (int'(cx) < SCREEN_COLUMNS) && (int'(pix_page) < SCREEN_PAGES);
  assign pix_addr = store_addr(pix_page, cx);

  // Each axis steps once its accumulated span passes the major span.
  assign ex_sum  = ex + ACC_W'(dx);
  assign ey_sum  = ey + ACC_W'(dy);
  assign ex_step = ex_sum > ACC_W'(major_span);
  assign ey_step = ey_sum > ACC_W'(major_span);

  always_comb begin
    case (state)
      ST_CLEAR: mem_addr = clr_addr;
      ST_IDLE:  mem_addr = q_job.rd_addr;
      default:  mem_addr = pix_addr;
    endcase
  end

  assign mem_we    = (state == ST_CLEAR) || ((state == ST_DRAW_WR) && pix_ok);
  assign mem_wdata = (state == ST_CLEAR) ? '0 :
                     pixel_value ? (rd_data | pix_mask) : (rd_data & ~pix_mask);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_data <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      clr_init  <= 1'b1;
      rsp_valid <= 1'b0;
    end else begin
      if (state == ST_RESULT && out_free) begin
        rsp_valid <= 1'b1;
      end else if (response.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cx          <= q_job.x;
            cy          <= q_job.y;
            ex          <= '0;
            ey          <= '0;
            dx          <= q_job.dx;
            dy          <= q_job.dy;
            major_span  <= q_job.major_span;
            remaining   <= q_job.major_span;
            x_neg       <= q_job.x_neg;
            y_neg       <= q_job.y_neg;
            pixel_value <= q_job.pixel_value;
            rd_ok       <= q_job.rd_ok;
            res_data    <= '0;
            clr_addr    <= '0;
            case (q_job.kind)
              JOB_DRAW:  state <= ST_DRAW_RD;
              JOB_CLEAR: state <= ST_CLEAR;
              JOB_READ:  state <= ST_READ_WAIT;
              default:   state <= ST_RESULT;
            endcase
          end
        end
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(STORE_SIZE - 1)) begin
            clr_init <= 1'b0;
            state    <= clr_init ? ST_IDLE : ST_RESULT;
          end
        end
        ST_DRAW_RD: begin
          state <= ST_DRAW_WR;
        end
        ST_DRAW_WR: begin
          if (ex_step) begin
            ex <= ex_sum - ACC_W'(major_span);
            cx <= x_neg ? cx - 1'b1 : cx + 1'b1;
          end else begin
            ex <= ex_sum;
          end
          if (ey_step) begin
            ey <= ey_sum - ACC_W'(major_span);
            cy <= y_neg ? cy - 1'b1 : cy + 1'b1;
          end else begin
            ey <= ey_sum;
          end
          remaining <= remaining - 1'b1;
          state     <= (remaining == '0) ? ST_RESULT : ST_DRAW_RD;
        end
        ST_READ_WAIT: begin
          res_data <= rd_ok ? rd_data : '0;
          state    <= ST_RESULT;
        end
        ST_RESULT: begin
          if (out_free) begin
            rsp_data  <= res_data;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The front end must hold off every command until the start-up wipe is done.
  a_init_queue_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR && clr_init) |-> !q_valid)
    else $error("job queued during start-up wipe");

  // Error accumulators never exceed the major span between pixels.
  a_acc_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAW_WR) |-> (ex <= ACC_W'(major_span) && ey <= ACC_W'(major_span)))
    else $error("line error accumulator out of range");

  // A finished job reaches the output register as soon as it is free.
  a_result_issued: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESULT && out_free) |=> (rsp_valid && state == ST_IDLE))
    else $error("result not issued");

  // The store is written only by a wipe or a pixel update.
  a_write_source: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_CLEAR || state == ST_DRAW_WR))
    else $error("unexpected framebuffer write");

endmodule

// ===== src/framebuffer_line_rasterizer_core.sv =====
// ----------------------------------------------------------------------------
// Framebuffer line rasterizer
// 128x64 monochrome page-organized framebuffer with line drawing, clearing
// and column-byte reads. One response transaction per command.
// ----------------------------------------------------------------------------
// Line draw: each pixel is a framebuffer read then a write; a command plots span+1
//   pixels, span being the larger axis span.
// Clear: one byte per cycle, over the whole store.
// A two-entry job queue lets commands be taken while the engine is busy.
// After reset the engine wipes the whole store; no command
//   transaction is taken until that is done.
module framebuffer_line_rasterizer_core (
  input  logic      clk,
  input  logic      rst,
  flr_cmd_if.sink   command,
  flr_rsp_if.source response
);
  import flr_pkg::*;

  logic init_busy;
  logic push;
  logic pop;
  logic q_full;
  logic q_valid;
  job_t push_job;
  job_t pop_job;

  flr_front u_front (
    .command   (command),
    .init_busy (init_busy),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  flr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (pop),
    .pop_job   (pop_job),
    .not_empty (q_valid)
  );

  flr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_job     (pop_job),
    .q_pop     (pop),
    .init_busy (init_busy),
    .response  (response)
  );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line rasterizer core testbench
// Drives draw, clear, read and unused-code commands into the rasterizer and
// keeps its own copy of the framebuffer. It predicts every response byte and
// checks each response transaction against the oldest prediction. Directed
// lines cover points, diagonals and the screen edges. Random traffic follows:
// mostly lines with reads aimed at their columns, plus clears and noise.
// Both channels idle at random, and one long receiver hold-off fills the core.
// ----------------------------------------------------------------------------
module tb_top;
  import flr_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_PER_PHASE = 260;
  localparam int HOLD_OFF_CYCLES  = 1500;
  localparam int DRAIN_CYCLES     = 1100;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [X_W-1:0]    x0;
    logic [Y_W-1:0]    y0;
    logic [X_W-1:0]    x1;
    logic [Y_W-1:0]    y1;
    logic              pixel_on;
    logic [X_W-1:0]    rd_col;
    logic [PAGE_W-1:0] rd_page;
  } cmd_item_t;

  logic clk;
  logic rst;

  flr_cmd_if command ();
  flr_rsp_if response ();

  framebuffer_line_rasterizer_core u_top (
    .clk      (clk),
    .rst      (rst),
    .command  (command),
    .response (response)
  );

  logic [BYTE_W-1:0] pixel_mem [STORE_SIZE];
  logic [BYTE_W-1:0] pending_bytes [$];
  int                mismatch_count;
  int                send_idle_pct;
  int                recv_idle_pct;
  int                hold_request;
  cmd_item_t         last_line;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Framebuffer model.
  function automatic void plot_pixel(input int x, input int y, input logic on);
    int idx;
    if (x < 0 || y < 0 || x >= SCREEN_COLUMNS || (y / 8) >= SCREEN_PAGES) return;
    idx = (y / 8) * SCREEN_COLUMNS + x;
    pixel_mem[idx][y % 8] = on;
  endfunction

  function automatic void raster_line(input cmd_item_t item);
    int dx, dy, sx, sy, span, ex, ey, cx, cy;
    dx = int'(item.x1) - int'(item.x0);
    dy = int'(item.y1) - int'(item.y0);
    sx = (dx > 0) ? 1 : ((dx == 0) ? 0 : -1);
    sy = (dy > 0) ? 1 : ((dy == 0) ? 0 : -1);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    span = (dx > dy) ? dx : dy;
    ex = 0;
    ey = 0;
    cx = int'(item.x0);
    cy = int'(item.y0);
    for (int n = 0; n <= span; n++) begin
      plot_pixel(cx, cy, item.pixel_on);
      ex += dx;
      ey += dy;
      if (ex > span) begin
        ex -= span;
        cx += sx;
      end
      if (ey > span) begin
        ey -= span;
        cy += sy;
      end
    end
  endfunction

  // Applies one command to the model and returns the byte it should answer.
  function automatic logic [BYTE_W-1:0] predict_read_data(input cmd_item_t item);
    logic [BYTE_W-1:0] data;
    data = '0;
    case (item.op)
      OP_DRAW: raster_line(item);
      OP_CLEAR: begin
        for (int i = 0; i < STORE_SIZE; i++) pixel_mem[i] = '0;
      end
      OP_READ: begin
        if (int'(item.rd_col) < SCREEN_COLUMNS && int'(item.rd_page) < SCREEN_PAGES)
          data = pixel_mem[int'(item.rd_page) * SCREEN_COLUMNS + int'(item.rd_col)];
      end
      default: data = '0;
    endcase
    return data;
  endfunction

  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("MISMATCH: %s", msg);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance,
  // leaving valid high so that a back-to-back transaction needs no re-raise.
  task automatic send_command(input cmd_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      command.valid = 1'b0;
      @(negedge clk);
    end
    command.valid       = 1'b1;
    command.operation   = item.op;
    command.x_start     = item.x0;
    command.y_start     = item.y0;
    command.x_end       = item.x1;
    command.y_end       = item.y1;
    command.pixel_value = item.pixel_on;
    command.read_column = item.rd_col;
    command.read_page   = item.rd_page;
    do @(posedge clk); while (!command.ready);
    pending_bytes.push_back(predict_read_data(item));
    if (item.op == OP_DRAW) last_line = item;
    @(negedge clk);
  endtask

  task automatic send_draw(input int x0, input int y0, input int x1, input int y1,
                           input logic on);
    cmd_item_t item;
    item = '0;
    item.op = OP_DRAW;
    item.x0 = X_W'(x0);
    item.y0 = Y_W'(y0);
    item.x1 = X_W'(x1);
    item.y1 = Y_W'(y1);
    item.pixel_on = on;
    send_command(item);
  endtask

  task automatic send_read(input int col, input int page);
    cmd_item_t item;
    item = '0;
    item.op = OP_READ;
    item.rd_col = X_W'(col);
    item.rd_page = PAGE_W'(page);
    send_command(item);
  endtask

  task automatic send_clear();
    cmd_item_t item;
    item = '0;
    item.op = OP_CLEAR;
    send_command(item);
  endtask

  function automatic int near_value(input int centre, input int top);
    int v;
    v = centre + $urandom_range(14) - 7;
    if (v < 0) v = 0;
    if (v > top) v = top;
    return v;
  endfunction

  function automatic cmd_item_t random_command();
    cmd_item_t item;
    logic [63:0] raw;
    int pick, lo, hi;
    raw = {$urandom, $urandom};
    item = raw[$bits(cmd_item_t)-1:0];
    pick = $urandom_range(99);
    if (pick < 45) begin
      item.op = OP_DRAW;
      // Short lines pack pixels into few bytes, so later reads see overlap.
      if ($urandom_range(99) < 35) begin
        item.x1 = X_W'(near_value(int'(item.x0), SCREEN_COLUMNS - 1));
        item.y1 = Y_W'(near_value(int'(item.y0), SCREEN_PAGES * 8 - 1));
      end
    end else if (pick < 92) begin
      item.op = OP_READ;
      if ($urandom_range(99) < 70) begin
        lo = (last_line.x0 < last_line.x1) ? last_line.x0 : last_line.x1;
        hi = (last_line.x0 < last_line.x1) ? last_line.x1 : last_line.x0;
        item.rd_col = X_W'($urandom_range(hi, lo));
        lo = ((last_line.y0 < last_line.y1) ? last_line.y0 : last_line.y1) / 8;
        hi = ((last_line.y0 < last_line.y1) ? last_line.y1 : last_line.y0) / 8;
        item.rd_page = PAGE_W'($urandom_range(hi, lo));
      end
    end else if (pick < 96) begin
      item.op = OP_CLEAR;
    end else begin
      item.op = OP_UNUSED;
    end
    return item;
  endfunction

  // Receiver: random idling, plus a long hold-off when one is requested.
  initial begin : drive_response_ready
    int hold_left;
    hold_left = 0;
    response.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        response.ready = 1'b0;
        hold_left--;
      end else begin
        response.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_response
    logic [BYTE_W-1:0] want;
    if (!rst && response.valid && response.ready) begin
      if (pending_bytes.size() == 0) begin
        note_failure($sformatf("unexpected response read_data=%02h", response.read_data));
      end else begin
        want = pending_bytes.pop_front();
        if (response.read_data !== want)
          note_failure($sformatf("read_data expected %02h actual %02h",
                                 want, response.read_data));
      end
    end
  end

  task automatic test_power_on_contents();
    send_read(0, 0);
    send_read(SCREEN_COLUMNS - 1, SCREEN_PAGES - 1);
  endtask

  task automatic test_point_and_edge_lines();
    send_draw(5, 5, 5, 5, 1'b1);
    send_read(5, 0);
    send_draw(0, 0, 127, 63, 1'b1);
    send_read(0, 0);
    send_read(127, 7);
    send_read(64, 4);
    send_draw(127, 0, 0, 63, 1'b1);
    send_read(127, 0);
    send_read(0, 7);
    send_draw(0, 63, 127, 63, 1'b1);
    send_read(100, 7);
    send_draw(127, 0, 127, 63, 1'b1);
    send_read(127, 3);
  endtask

  task automatic test_erase_and_clear();
    cmd_item_t item;
    send_draw(0, 0, 127, 63, 1'b0);
    send_read(64, 4);
    send_read(127, 7);
    // An unused code with every field at its top value must change nothing.
    item = '1;
    item.op = OP_UNUSED;
    send_command(item);
    send_read(127, 7);
    send_clear();
    send_read(127, 7);
    send_read(0, 7);
  endtask

  task automatic test_random_traffic(input int count, input int snd_pct, input int rcv_pct);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    for (int i = 0; i < count; i++) send_command(random_command());
  endtask

  // The receiver stops for a long stretch while commands keep coming, so the
  // job queue fills and the command channel is held back.
  task automatic test_input_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = HOLD_OFF_CYCLES;
    for (int i = 0; i < 20; i++) send_command(random_command());
  endtask

  initial begin
    rst = 1'b1;
    mismatch_count = 0;
    send_idle_pct = 7;
    recv_idle_pct = 83;
    hold_request = 0;
    last_line = '0;
    for (int i = 0; i < STORE_SIZE; i++) pixel_mem[i] = '0;
    command.valid = 1'b0;
    command.operation = OP_DRAW;
    command.x_start = '0;
    command.y_start = '0;
    command.x_end = '0;
    command.y_end = '0;
    command.pixel_value = 1'b0;
    command.read_column = '0;
    command.read_page = '0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    test_power_on_contents();
    test_point_and_edge_lines();
    test_erase_and_clear();
    test_random_traffic(RANDOM_PER_PHASE, 7, 83);
    test_random_traffic(RANDOM_PER_PHASE, 83, 7);
    test_random_traffic(RANDOM_PER_PHASE, 0, 0);
    test_input_stall();
    command.valid = 1'b0;

    while (pending_bytes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending_bytes.size() != 0)
      note_failure($sformatf("%0d responses never arrived", pending_bytes.size()));

    if (mismatch_count == 0) begin
      $display("framebuffer_line_rasterizer_core verification clean");
    end else begin
      $display("framebuffer_line_rasterizer_core verification failed");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("framebuffer_line_rasterizer_core verification failed");
    $finish;
  end

endmodule
